### hw/rtl/counting_semaphore_table_assert.svh
// Assertion macros used by the semaphore table top level.
`ifndef COUNTING_SEMAPHORE_TABLE_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSEM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Semaphore table assertion failed.");

// Next-cycle implication, disabled while reset is asserted.
`define CSEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Semaphore table assertion failed.");

`endif

### hw/rtl/csem_pkg.sv
// Types, constants and codes of the counting semaphore table.
`timescale 1ns / 1ps
package csem_pkg;

  localparam int NUM_RESOURCES_DEF = 16;
  localparam int NUM_WAITERS_DEF   = 16;
  localparam int COUNT_BITS_DEF    = 8;
  localparam int TASK_BITS_DEF     = 8;

  localparam int RES_ID_W  = 4;
  localparam int TASK_ID_W = 8;
  localparam int COUNT_W   = 8;

  localparam logic ACT_WAIT   = 1'b0;
  localparam logic ACT_SIGNAL = 1'b1;

  localparam logic [COUNT_W-1:0] NEW_COUNT_RESET = 8'd1;

  typedef struct packed {
    logic                 action;
    logic [TASK_ID_W-1:0] task_id;
    logic [RES_ID_W-1:0]  resource_id;
  } in_item_t;

  typedef struct packed {
    logic                 verdict;
    logic                 woke_valid;
    logic [TASK_ID_W-1:0] woke_task_id;
    logic                 queue_full;
    logic [COUNT_W-1:0]   count_after;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } csem_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } csem_cmd_t;

endpackage

### hw/rtl/csem_ctrl.sv
// Controller state machine that sequences one transaction at a time.
`timescale 1ns / 1ps
module csem_ctrl
  import csem_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output csem_cmd_t cmd
);

  csem_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_ready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/csem_dpath.sv
// Datapath: count memory, created flags, ordered waiter list and result register.
`timescale 1ns / 1ps
module csem_dpath
  import csem_pkg::*;
#(
  parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int NUM_WAITERS   = NUM_WAITERS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  parameter int TASK_BITS     = TASK_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csem_cmd_t          cmd,
  input  in_item_t           in_data,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  output out_item_t          out_data
);

  localparam int RW   = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int WIW  = $clog2(NUM_WAITERS);
  localparam int FW   = $clog2(NUM_WAITERS + 1);
  localparam int CW   = COUNT_BITS;
  localparam int CMW  = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int NIDS = 2 ** RES_ID_W;
  localparam logic [CW-1:0] COUNT_MAX = '1;
  localparam logic [FW-1:0] FILL_MAX  = FW'(NUM_WAITERS);

  logic [COUNT_W-1:0]       new_count_r;
  in_item_t                 item_r;
  logic [RW-1:0]            idx_r;
  logic [CW-1:0]            rd_data_r;
  logic [CW-1:0]            cnt_mem [NUM_RESOURCES];
  logic [NUM_RESOURCES-1:0] known_r;
  logic [TASK_BITS-1:0]     wtask_r [NUM_WAITERS];
  logic [RW-1:0]            wres_r  [NUM_WAITERS];
  logic [FW-1:0]            fill_r;
  out_item_t                out_r;

  logic [RW-1:0]          mod_tbl [NIDS];
  logic [RW-1:0]          in_idx;
  logic [CW-1:0]          init_cnt, cur_cnt, new_cnt;
  logic [NUM_WAITERS-1:0] match, hot, ge_mask;
  logic                   hit, list_full, push, pop;
  logic                   verdict, queue_full;
  logic [TASK_BITS-1:0]   woke_task;
  logic [TASK_BITS-1:0]   item_task;
  logic [WIW-1:0]         tail;

  for (genvar g = 0; g < NIDS; g++) begin : g_mod
    localparam int MV = g % NUM_RESOURCES;
    assign mod_tbl[g] = RW'(MV);
  end

  assign in_idx = mod_tbl[in_data.resource_id];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_count_r <= NEW_COUNT_RESET;
    end else if (cfg_we) begin
      new_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r    <= in_data;
      idx_r     <= in_idx;
      rd_data_r <= cnt_mem[in_idx];
    end
    if (cmd.exec) begin
      cnt_mem[idx_r] <= new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= '0;
      fill_r  <= '0;
    end else if (cmd.exec) begin
      known_r[idx_r] <= 1'b1;
      if (push) begin
        fill_r <= fill_r + FW'(1);
      end else if (pop) begin
        fill_r <= fill_r - FW'(1);
      end
    end
  end

  assign init_cnt = (CMW'(new_count_r) > CMW'(COUNT_MAX)) ? COUNT_MAX : CW'(new_count_r);
  assign cur_cnt  = known_r[idx_r] ? rd_data_r : init_cnt;

  for (genvar g = 0; g < NUM_WAITERS; g++) begin : g_match
    assign match[g] = (FW'(g) < fill_r) && (wres_r[g] == idx_r);
  end

  assign hot       = match & ~(match - NUM_WAITERS'(1));
  assign ge_mask   = ~(hot - NUM_WAITERS'(1));
  assign hit       = |match;
  assign list_full = (fill_r == FILL_MAX);
  assign tail      = fill_r[WIW-1:0];
  assign item_task = TASK_BITS'(item_r.task_id);

  always_comb begin
    woke_task = '0;
    for (int i = 0; i < NUM_WAITERS; i++) begin
      woke_task = woke_task | (hot[i] ? wtask_r[i] : '0);
    end
  end

  always_comb begin
    new_cnt    = cur_cnt;
    verdict    = 1'b0;
    queue_full = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    if (item_r.action == ACT_WAIT) begin
      if (cur_cnt != '0) begin
        new_cnt = cur_cnt - CW'(1);
      end else begin
        verdict = 1'b1;
        if (list_full) begin
          queue_full = 1'b1;
        end else begin
          push = 1'b1;
        end
      end
    end else begin
      if (hit) begin
        pop = 1'b1;
      end else if (cur_cnt != COUNT_MAX) begin
        new_cnt = cur_cnt + CW'(1);
      end
    end
  end

  for (genvar g = 0; g < NUM_WAITERS; g++) begin : g_entry
    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (push && (tail == WIW'(g))) begin
          wtask_r[g] <= item_task;
          wres_r[g]  <= idx_r;
        end else if (pop && ge_mask[g]) begin
          if (g < NUM_WAITERS - 1) begin
            wtask_r[g] <= wtask_r[(g + 1) % NUM_WAITERS];
            wres_r[g]  <= wres_r[(g + 1) % NUM_WAITERS];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r.verdict      <= verdict;
      out_r.woke_valid   <= pop;
      out_r.woke_task_id <= pop ? TASK_ID_W'(woke_task) : '0;
      out_r.queue_full   <= queue_full;
      out_r.count_after  <= COUNT_W'(new_cnt);
    end
  end

  assign out_data = out_r;

endmodule

### hw/rtl/counting_semaphore_table.sv
// Top level of the counting semaphore table with a shared ordered wait queue.
// Each accepted wait or signal transaction returns exactly one result. The block
// works on one transaction at a time: a capture step reads the resource count
// memory, and an execute step searches the waiter list, updates count and list,
// and loads the result register. A finished result waits in the output register
// while the next transaction is accepted; a new result is loaded only after the
// previous one has been taken. New resources start with the count held in the
// configuration register (reset value 1), saturated to the count width.
`timescale 1ns / 1ps
module counting_semaphore_table
  import csem_pkg::*;
#(
  parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int NUM_WAITERS   = NUM_WAITERS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  parameter int TASK_BITS     = TASK_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

`include "counting_semaphore_table_assert.svh"

  csem_cmd_t cmd;

  csem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  csem_dpath #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .NUM_WAITERS   (NUM_WAITERS),
    .COUNT_BITS    (COUNT_BITS),
    .TASK_BITS     (TASK_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

  `CSEM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `CSEM_ASSERT_NOW(a_no_result_overwrite, clk, rst_n, cmd.exec, !out_valid || out_ready)
  `CSEM_ASSERT_NEXT(a_result_after_exec, clk, rst_n, cmd.exec, out_valid && in_ready)

endmodule

### tb/tb_top.sv
// Self-checking testbench of the counting semaphore table with its wait-list scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import csem_pkg::*;

  localparam int COUNT_MAX      = (1 << COUNT_BITS_DEF) - 1;
  localparam int TASK_MASK      = (1 << TASK_BITS_DEF) - 1;
  localparam int HOLD_CYCLES    = 80;
  localparam int CFG_SETTLE     = 4;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 150;

  class semaphore_scoreboard;
    logic [COUNT_W-1:0]   start_count;
    logic [COUNT_W-1:0]   count_of [NUM_RESOURCES_DEF];
    bit                   created [NUM_RESOURCES_DEF];
    logic [TASK_ID_W-1:0] queued_task [NUM_WAITERS_DEF];
    logic [RES_ID_W-1:0]  queued_res [NUM_WAITERS_DEF];
    int                   queue_len;
    out_item_t            replies_due [$];
    int                   errors;

    function new();
      start_count = NEW_COUNT_RESET;
      queue_len = 0;
      errors = 0;
      for (int i = 0; i < NUM_RESOURCES_DEF; i++) begin
        count_of[i] = '0;
        created[i] = 1'b0;
      end
    endfunction

    function void set_start_count(logic [COUNT_W-1:0] value);
      start_count = value;
    endfunction

    function int outstanding();
      return replies_due.size();
    endfunction

    function void note_request(in_item_t req);
      out_item_t reply;
      int r;
      int hit;
      reply = '0;
      r = req.resource_id % NUM_RESOURCES_DEF;
      if (!created[r]) begin
        count_of[r] = (start_count > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : start_count;
        created[r] = 1'b1;
      end
      if (req.action == ACT_WAIT) begin
        if (count_of[r] != 0) begin
          count_of[r] = count_of[r] - 1'b1;
        end else begin
          reply.verdict = 1'b1;
          if (queue_len == NUM_WAITERS_DEF) begin
            reply.queue_full = 1'b1;
          end else begin
            queued_task[queue_len] = req.task_id & TASK_MASK[TASK_ID_W-1:0];
            queued_res[queue_len] = r[RES_ID_W-1:0];
            queue_len++;
          end
        end
      end else begin
        hit = -1;
        for (int i = 0; i < queue_len; i++) begin
          if (hit < 0 && queued_res[i] == r) hit = i;
        end
        if (hit >= 0) begin
          reply.woke_valid = 1'b1;
          reply.woke_task_id = queued_task[hit];
          for (int i = hit; i + 1 < queue_len; i++) begin
            queued_task[i] = queued_task[i + 1];
            queued_res[i] = queued_res[i + 1];
          end
          queue_len--;
        end else if (count_of[r] < COUNT_MAX) begin
          count_of[r] = count_of[r] + 1'b1;
        end
      end
      reply.count_after = count_of[r];
      replies_due.push_back(reply);
    endfunction

    function void compare_field(string name, logic [15:0] expv, logic [15:0] actv);
      if (expv !== actv) begin
        $error("%s: expected %0h, actual %0h", name, expv, actv);
        errors++;
      end
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        $error("Result transaction arrived with no request outstanding.");
        errors++;
        return;
      end
      want = replies_due.pop_front();
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("woke_valid", want.woke_valid, got.woke_valid);
      compare_field("woke_task_id", want.woke_task_id, got.woke_task_id);
      compare_field("queue_full", want.queue_full, got.queue_full);
      compare_field("count_after", want.count_after, got.count_after);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;

  semaphore_scoreboard book = new();
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  logic                hold_req = 1'b0;
  logic                hold_taken = 1'b0;
  int                  hold_left = 0;
  int                  quiet_cycles = 0;
  int                  wait_share [PHASES] = '{60, 75, 40, 55, 85, 45};
  logic [7:0]          count_plan [PHASES] = '{8'd1, 8'd0, 8'd255, 8'd0, 8'd2, 8'd0};

  counting_semaphore_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_reply(out_data);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  function automatic in_item_t make_item(logic act, logic [TASK_ID_W-1:0] tid,
                                         logic [RES_ID_W-1:0] rid);
    in_item_t req;
    req.action = act;
    req.task_id = tid;
    req.resource_id = rid;
    return req;
  endfunction

  task automatic send_item(input in_item_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_request(req);
  endtask

  task automatic write_start_count(input logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_start_count(value);
  endtask

  initial begin
    logic                act;
    logic [RES_ID_W-1:0] rid;
    logic [COUNT_W-1:0]  start_value;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill and overflow the shared wait list from a zero count, then wake three waiters.
    write_start_count(8'd0);
    send_item(make_item(ACT_WAIT, 8'h00, 4'd0));
    send_item(make_item(ACT_WAIT, 8'hFF, 4'd15));
    for (int n = 0; n < 14; n++) begin
      send_item(make_item(ACT_WAIT, (n % 6 == 1) ? 8'h5A : 8'(n * 19), 4'd3));
    end
    send_item(make_item(ACT_WAIT, 8'h33, 4'd3));
    send_item(make_item(ACT_SIGNAL, 8'h00, 4'd3));
    send_item(make_item(ACT_SIGNAL, 8'h81, 4'd0));
    send_item(make_item(ACT_SIGNAL, 8'h7E, 4'd15));
    send_item(make_item(ACT_SIGNAL, 8'h00, 4'd5));

    // A resource created at the top count must saturate on a signal.
    write_start_count(8'd255);
    send_item(make_item(ACT_SIGNAL, 8'hAA, 4'd7));
    send_item(make_item(ACT_WAIT, 8'h55, 4'd7));
    send_item(make_item(ACT_WAIT, 8'hC3, 4'd3));

    for (int p = 0; p < PHASES; p++) begin
      start_value = (p == 3 || p == 5) ? 8'($urandom_range(1, 254)) : count_plan[p];
      write_start_count(start_value);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 48;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 48;
        end
        default: begin
          send_idle_pct = 35;
          recv_stall_pct = 35;
        end
      endcase
      if (p == 0) hold_req <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        act = ($urandom_range(0, 99) < wait_share[p]) ? ACT_WAIT : ACT_SIGNAL;
        rid = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 3))
                                           : 4'($urandom_range(0, 15));
        send_item(make_item(act, 8'($urandom_range(0, 255)), rid));
      end
    end

    in_valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
